// ===== rtl/ps2_mouse_packet_tracker_core_macros.svh =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker assertion macros
// Concurrent assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PMT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pmt assertion failed");

// Check a property on every rising clock edge, reset included.
`define PMT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pmt assertion failed");

`endif

// ===== rtl/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Types, header masks and button codes shared by the tracker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmt_pkg;

    localparam int CFG_BITS = 13;

    localparam logic [7:0] HDR_OVERFLOW_MASK = 8'hc0;
    localparam int HDR_X_SIGN_BIT = 4;
    localparam int HDR_Y_SIGN_BIT = 5;

    typedef logic [2:0] buttons_t;

    localparam buttons_t BTN_NONE  = 3'd0;
    localparam buttons_t BTN_LEFT  = 3'd4;
    localparam buttons_t BTN_RIGHT = 3'd1;
    localparam buttons_t BTN_BOTH  = 3'd5;

    typedef enum logic [1:0] {
        EV_LEFT_DOWN = 2'd0,
        EV_LEFT_UP   = 2'd1,
        EV_LEFT_MOVE = 2'd2,
        EV_OTHER     = 2'd3
    } mouse_event_t;

    typedef enum logic {
        REG_LIMIT_X = 1'b0,
        REG_LIMIT_Y = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0] byte_count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        buttons_t   last_buttons;
    } pkt_state_t;

    typedef struct packed {
        logic         status;
        mouse_event_t mouse_event;
    } pkt_result_t;

    // Header bits 1..0 only; the middle button bit is ignored.
    function automatic buttons_t btn_map(input logic [1:0] hdr_btn);
        buttons_t code;
        case (hdr_btn)
            2'd0:    code = BTN_NONE;
            2'd1:    code = BTN_LEFT;
            2'd2:    code = BTN_RIGHT;
            default: code = BTN_BOTH;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/pmt_decode.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decode step
// Next packet state, pointer position and result for one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmt_decode #(
    parameter int COORD_BITS = 12
) (
    input  pmt_pkg::pkt_state_t          state,
    input  logic [COORD_BITS-1:0]        cur_x,
    input  logic [COORD_BITS-1:0]        cur_y,
    input  logic [pmt_pkg::CFG_BITS-1:0] x_limit,
    input  logic [pmt_pkg::CFG_BITS-1:0] y_limit,
    input  logic [7:0]                   data_byte,
    output pmt_pkg::pkt_state_t          state_next,
    output logic [COORD_BITS-1:0]        x_next,
    output logic [COORD_BITS-1:0]        y_next,
    output logic                         has_result,
    output pmt_pkg::pkt_result_t         result
);

    localparam int CW = ((COORD_BITS > pmt_pkg::CFG_BITS) ? COORD_BITS : pmt_pkg::CFG_BITS) + 2;

    function automatic logic [COORD_BITS-1:0] move_axis(
        input logic [COORD_BITS-1:0]        cur,
        input logic signed [CW-1:0]         delta,
        input logic [pmt_pkg::CFG_BITS-1:0] lim_reg
    );
        logic [CW-1:0]        cap;
        logic [CW-1:0]        reg_ext;
        logic [CW-1:0]        lim;
        logic signed [CW-1:0] n;
        cap     = CW'(1) << COORD_BITS;
        reg_ext = {{(CW-pmt_pkg::CFG_BITS){1'b0}}, lim_reg};
        lim     = (reg_ext < cap) ? reg_ext : cap;
        n       = $signed({{(CW-COORD_BITS){1'b0}}, cur}) + delta;
        if (delta != '0 && !n[CW-1] && $unsigned(n) < lim)
            return n[COORD_BITS-1:0];
        return cur;
    endfunction

    logic [7:0]           hdr;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    pmt_pkg::buttons_t    bp;
    pmt_pkg::mouse_event_t ev;

    assign hdr = state.first_byte;
    assign bp  = pmt_pkg::btn_map(hdr[1:0]);
    assign dx  = CW'($signed({hdr[pmt_pkg::HDR_X_SIGN_BIT], state.second_byte}));
    assign dy  = -CW'($signed({hdr[pmt_pkg::HDR_Y_SIGN_BIT], data_byte}));

    always_comb
    begin
        if (state.last_buttons == pmt_pkg::BTN_NONE && bp == pmt_pkg::BTN_LEFT)
            ev = pmt_pkg::EV_LEFT_DOWN;
        else if (state.last_buttons == pmt_pkg::BTN_LEFT && bp == pmt_pkg::BTN_NONE)
            ev = pmt_pkg::EV_LEFT_UP;
        else if (state.last_buttons == pmt_pkg::BTN_LEFT && bp == pmt_pkg::BTN_LEFT)
            ev = pmt_pkg::EV_LEFT_MOVE;
        else
            ev = pmt_pkg::EV_OTHER;
    end

    always_comb
    begin
        state_next         = state;
        x_next             = cur_x;
        y_next             = cur_y;
        has_result         = 1'b0;
        result.status      = 1'b0;
        result.mouse_event = pmt_pkg::EV_OTHER;
        case (state.byte_count)
            2'd0:
            begin
                state_next.first_byte = data_byte;
                state_next.byte_count = 2'd1;
            end
            2'd1:
            begin
                state_next.second_byte = data_byte;
                state_next.byte_count  = 2'd2;
            end
            default:
            begin
                has_result = 1'b1;
                if ((hdr & pmt_pkg::HDR_OVERFLOW_MASK) != 8'd0)
                begin
                    // Drop the header, keep the two later bytes.
                    state_next.first_byte  = state.second_byte;
                    state_next.second_byte = data_byte;
                    state_next.byte_count  = 2'd2;
                    result.status          = 1'b1;
                end
                else
                begin
                    state_next.byte_count   = 2'd0;
                    state_next.last_buttons = bp;
                    x_next                  = move_axis(cur_x, dx, x_limit);
                    y_next                  = move_axis(cur_y, dy, y_limit);
                    result.mouse_event      = ev;
                end
            end
        endcase
    end

endmodule

// ===== rtl/ps2_mouse_packet_tracker_core.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// A completing byte goes through the input register, then decode, then the result register.
// Throughput: one byte per cycle unless a held result is stalled; input register, decode, result register.
// A byte waits in the input register only while a held result is stalled.
// Reset clears the packet state, position and both valids; limits go to
// 640 by 480.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  logic [7:0]            data_byte,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  status,
    output logic [COORD_BITS-1:0] pos_x,
    output logic [COORD_BITS-1:0] pos_y,
    output logic [1:0]            mouse_event
);

    localparam int CB = pmt_pkg::CFG_BITS;

    logic [CB-1:0]         width_reg, width_next;
    logic [CB-1:0]         height_reg, height_next;
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg, in_byte_next;
    pmt_pkg::pkt_state_t   pkt_reg, pkt_next;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic                  out_valid_reg, out_valid_next;
    pmt_pkg::pkt_result_t  out_res_reg, out_res_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic [COORD_BITS-1:0] out_y_reg, out_y_next;

    pmt_pkg::pkt_state_t   dec_state;
    logic [COORD_BITS-1:0] dec_x;
    logic [COORD_BITS-1:0] dec_y;
    logic                  dec_has_result;
    pmt_pkg::pkt_result_t  dec_result;

    logic                  cfg_write;
    logic                  out_free;
    logic                  in_fire;
    logic                  byte_accept;

    pmt_decode #(
        .COORD_BITS (COORD_BITS)
    ) u_decode (
        .state         (pkt_reg),
        .cur_x         (cur_x_reg),
        .cur_y         (cur_y_reg),
        .x_limit       (width_reg),
        .y_limit       (height_reg),
        .data_byte     (in_byte_reg),
        .state_next    (dec_state),
        .x_next        (dec_x),
        .y_next        (dec_y),
        .has_result    (dec_has_result),
        .result        (dec_result)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (pmt_pkg::reg_index_t'(paddr[2]))
            pmt_pkg::REG_LIMIT_X: prdata = {{(32-CB){1'b0}}, width_reg};
            pmt_pkg::REG_LIMIT_Y: prdata = {{(32-CB){1'b0}}, height_reg};
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            case (pmt_pkg::reg_index_t'(paddr[2]))
                pmt_pkg::REG_LIMIT_X: width_next  = pwdata[CB-1:0];
                pmt_pkg::REG_LIMIT_Y: height_next = pwdata[CB-1:0];
                default:              width_next  = width_reg;
            endcase
        end
    end

    assign out_free    = !out_valid_reg || !result_stall;
    assign in_fire     = in_valid_reg && (!dec_has_result || out_free);
    assign byte_stall  = in_valid_reg && !in_fire;
    assign byte_accept = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        pkt_next       = pkt_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;

        if (in_fire)
        begin
            pkt_next   = dec_state;
            cur_x_next = dec_x;
            cur_y_next = dec_y;
        end

        if (byte_accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = data_byte;
        end
        else if (in_fire)
            in_valid_next = 1'b0;

        if (in_fire && dec_has_result)
        begin
            out_valid_next = 1'b1;
            out_res_next   = dec_result;
            out_x_next     = dec_x;
            out_y_next     = dec_y;
        end
        else if (out_free)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= CB'(640);
            height_reg    <= CB'(480);
            in_valid_reg  <= 1'b0;
            pkt_reg       <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            in_valid_reg  <= in_valid_next;
            pkt_reg       <= pkt_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_res_reg <= out_res_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_res_reg.status;
    assign mouse_event  = out_res_reg.mouse_event;
    assign pos_x        = out_x_reg;
    assign pos_y        = out_y_reg;

endmodule

// ===== rtl/pmt_checker.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker port checker
// Port-level assertions on the byte and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_core_macros.svh"

module pmt_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  byte_valid,
    input logic                  byte_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic                  status,
    input logic [COORD_BITS-1:0] pos_x,
    input logic [COORD_BITS-1:0] pos_y,
    input logic [1:0]            mouse_event
);

    `PMT_ASSERT(a_result_hold, clk, rst_n, result_valid && result_stall |=> result_valid && $stable(status) && $stable(pos_x) && $stable(pos_y) && $stable(mouse_event))
    `PMT_ASSERT(a_resync_other, clk, rst_n, result_valid && status |-> mouse_event == pmt_pkg::EV_OTHER)
    `PMT_ASSERT(a_result_needs_byte, clk, rst_n, $rose(result_valid) |-> $past(byte_valid && !byte_stall, 2))
    `PMT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !result_valid)

endmodule

bind ps2_mouse_packet_tracker_core pmt_checker #(
    .COORD_BITS (COORD_BITS)
) u_pmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .mouse_event  (mouse_event)
);
